>>> src/r2fft_pkg.sv
package r2fft_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int SMP_W = 16;
  localparam int BIN_W = 24;
  localparam int ACC_W = 24;
  localparam int SIZE_W = 3;
  localparam int ROM_POINTS = 64;

  localparam logic [0:0] CFG_SIZE = 1'b0;
  localparam logic [0:0] CFG_MODE = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_A,
    ST_RD_B,
    ST_MUL,
    ST_WR_A,
    ST_WR_B,
    ST_OUT_RD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       wr_smp;
    logic       rd_a;
    logic       rd_b;
    logic       mul;
    logic       wr_a;
    logic       wr_b;
    logic       out_rd;
    logic       out_load;
  } cmd_t;

  function automatic logic signed [16:0] cos_rom(input logic [4:0] k);
    logic signed [16:0] v;
    case (k)
      5'd0: v = 17'sd32768;
      5'd1: v = 17'sd32610;
      5'd2: v = 17'sd32138;
      5'd3: v = 17'sd31357;
      5'd4: v = 17'sd30274;
      5'd5: v = 17'sd28899;
      5'd6: v = 17'sd27246;
      5'd7: v = 17'sd25330;
      5'd8: v = 17'sd23170;
      5'd9: v = 17'sd20788;
      5'd10: v = 17'sd18205;
      5'd11: v = 17'sd15447;
      5'd12: v = 17'sd12540;
      5'd13: v = 17'sd9512;
      5'd14: v = 17'sd6393;
      5'd15: v = 17'sd3212;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [16:0] tw_cos(input logic [4:0] t);
    logic signed [16:0] v;
    if (t <= 5'd16) v = cos_rom(t);
    else v = -cos_rom(5'(6'd32 - {1'b0, t}));
    return v;
  endfunction

  function automatic logic signed [16:0] tw_sin(input logic [4:0] t);
    logic signed [16:0] v;
    if (t <= 5'd16) v = cos_rom(5'(5'd16 - t));
    else v = cos_rom(5'(t - 5'd16));
    return v;
  endfunction

endpackage

>>> src/radix2_fft_frame_core.sv
// Frame FFT core, radix-2 DIT, N = 2^size_log2 points (2..MAX_POINTS). Samples are written
// at bit-reversed addresses, one per cycle. After the last sample the core runs
// N/2*log2(N) butterflies, each in states ST_RD_A..ST_WR_B, via the single-port-read
// sample RAM and one complex multiplier, then emits N bins, each held until taken. No
// sample is taken from the end of loading until the last bin has been delivered. Forward
// frames are scaled by 1/N; inverse frames are not. Configuration writes are taken only
// while loading and hold off the sample input in that cycle.
module radix2_fft_frame_core #(
  parameter int MAX_POINTS = r2fft_pkg::MAX_POINTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [r2fft_pkg::SMP_W-1:0] in_sample_re,
  input  logic signed [r2fft_pkg::SMP_W-1:0] in_sample_im,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [r2fft_pkg::BIN_W-1:0] out_bin_re,
  output logic signed [r2fft_pkg::BIN_W-1:0] out_bin_im,
  output logic out_last_bin,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [r2fft_pkg::SIZE_W-1:0] cfg_data
);
  import r2fft_pkg::*;

  localparam int MAXL = (MAX_POINTS >= 64) ? 6 : $clog2(MAX_POINTS + 1) - 1;

  logic [SIZE_W-1:0] size_r;
  logic inv_r;
  logic [2:0] eff_l;
  state_t state;
  cmd_t cmd;
  logic frame_done, bfly_last, out_last, in_fire, cfg_fire;

  assign cfg_ready = (state == ST_LOAD);
  assign cfg_fire = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 3'd6;
      inv_r <= 1'b0;
    end else if (cfg_fire) begin
      if (cfg_index == CFG_SIZE) size_r <= cfg_data;
      else inv_r <= cfg_data[0];
    end
  end

  always_comb begin
    eff_l = size_r;
    if (eff_l < 3'd1) eff_l = 3'd1;
    if (eff_l > 3'(MAXL)) eff_l = 3'(MAXL);
  end

  assign in_ready = (state == ST_LOAD) && !cfg_valid;
  assign in_fire = in_valid && in_ready;
  assign out_valid = (state == ST_OUT);

  r2fft_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .frame_done(frame_done),
    .bfly_last(bfly_last), .out_last(out_last), .out_ready(out_ready),
    .state(state), .cmd(cmd)
  );

  r2fft_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .state(state),
    .sample_re(in_sample_re), .sample_im(in_sample_im),
    .cfg_size_wr(cfg_fire && cfg_index == CFG_SIZE), .eff_l(eff_l), .inv(inv_r),
    .frame_done(frame_done), .bfly_last(bfly_last), .out_last(out_last),
    .bin_re(out_bin_re), .bin_im(out_bin_im)
  );

  assign out_last_bin = out_last;

  a_noin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during output");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_bin) |=> cfg_ready)
    else $error("no return to load after last bin");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("load and output overlap");

endmodule

>>> src/r2fft_ram.sv
module r2fft_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> src/r2fft_ctrl.sv
module r2fft_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic frame_done,
  input  logic bfly_last,
  input  logic out_last,
  input  logic out_ready,
  output r2fft_pkg::state_t state,
  output r2fft_pkg::cmd_t   cmd
);
  import r2fft_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: if (in_fire && frame_done) state_nxt = ST_RD_A;
      ST_RD_A: state_nxt = ST_RD_B;
      ST_RD_B: state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_WR_A;
      ST_WR_A: state_nxt = ST_WR_B;
      ST_WR_B: state_nxt = bfly_last ? ST_OUT_RD : ST_RD_A;
      ST_OUT_RD: state_nxt = ST_OUT;
      ST_OUT: if (out_ready) state_nxt = out_last ? ST_LOAD : ST_OUT_RD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_LOAD: cmd.wr_smp = in_fire;
      ST_RD_A: cmd.rd_a = 1'b1;
      ST_RD_B: cmd.rd_b = 1'b1;
      ST_MUL: cmd.mul = 1'b1;
      ST_WR_A: cmd.wr_a = 1'b1;
      ST_WR_B: cmd.wr_b = 1'b1;
      ST_OUT_RD: cmd.out_rd = 1'b1;
      ST_OUT: cmd.out_load = out_ready;
      default: cmd = '0;
    endcase
  end

  assign state = state_r;

endmodule

>>> src/r2fft_dp.sv
module r2fft_dp #(
  parameter int MAX_POINTS = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  r2fft_pkg::cmd_t   cmd,
  input  r2fft_pkg::state_t state,
  input  logic [r2fft_pkg::SMP_W-1:0] sample_re,
  input  logic [r2fft_pkg::SMP_W-1:0] sample_im,
  input  logic                        cfg_size_wr,
  input  logic [2:0]                  eff_l,
  input  logic                        inv,
  output logic frame_done,
  output logic bfly_last,
  output logic out_last,
  output logic signed [r2fft_pkg::BIN_W-1:0] bin_re,
  output logic signed [r2fft_pkg::BIN_W-1:0] bin_im
);
  import r2fft_pkg::*;

  localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int DW = 2 * ACC_W;

  logic [AW:0] cnt_r;
  logic [AW-1:0] rev;
  logic [2:0] stg_r;
  logic [AW-1:0] bidx_r;
  logic [AW-1:0] outi_r;
  logic inv_r;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  logic signed [ACC_W-1:0] ar_r, ai_r;
  logic signed [16:0] wr_r, wi_r;
  logic signed [ACC_W+17:0] pr_r, pi_r;
  logic signed [ACC_W-1:0] tr, ti;

  logic [AW:0] nm1;
  assign nm1 = (AW+1)'(((AW+1)'(1) << eff_l) - 1'b1);

  always_comb begin
    rev = '0;
    for (int b = 0; b < AW; b++)
      if (b < eff_l) rev[b] = cnt_r[eff_l - 3'(b) - 3'd1];
  end

  assign frame_done = (cnt_r == nm1);

  logic [AW-1:0] half, aidx, bidx_addr, jj;
  logic [4:0] tw;
  assign half = AW'((AW+1)'(1) << (stg_r - 3'd1));
  assign jj = bidx_r & (half - 1'b1);
  assign aidx = AW'((({1'b0, bidx_r} - {1'b0, jj}) << 1) + {1'b0, jj});
  assign bidx_addr = aidx + half;
  assign tw = 5'((11'(jj) << (3'd6 - stg_r)) & 11'd31);
  assign bfly_last = (stg_r == eff_l) &&
                     ({1'b0, bidx_r} == (AW+1)'(nm1 >> 1));
  assign out_last = ({1'b0, outi_r} == nm1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      stg_r <= 3'd1;
      bidx_r <= '0;
      outi_r <= '0;
      inv_r <= 1'b0;
    end else begin
      if (cfg_size_wr) cnt_r <= '0;
      else if (cmd.wr_smp) cnt_r <= frame_done ? '0 : cnt_r + 1'b1;
      if (cmd.wr_smp && frame_done) begin
        inv_r <= inv;
        stg_r <= 3'd1;
        bidx_r <= '0;
        outi_r <= '0;
      end
      if (cmd.wr_b) begin
        if ({1'b0, bidx_r} == (AW+1)'(nm1 >> 1)) begin
          bidx_r <= '0;
          stg_r <= stg_r + 3'd1;
        end else bidx_r <= bidx_r + 1'b1;
      end
      if (cmd.out_load) outi_r <= outi_r + 1'b1;
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = aidx;
    wdata = {ACC_W'($signed(sample_re)), ACC_W'($signed(sample_im))};
    raddr = aidx;
    if (cmd.wr_smp) begin
      we = 1'b1;
      waddr = rev;
    end else if (cmd.wr_a) begin
      we = 1'b1;
      wdata = {ACC_W'(ar_r + tr), ACC_W'(ai_r + ti)};
    end else if (cmd.wr_b) begin
      we = 1'b1;
      waddr = bidx_addr;
      wdata = {ACC_W'(ar_r - tr), ACC_W'(ai_r - ti)};
    end
    if (cmd.rd_a) raddr = aidx;
    else if (cmd.rd_b) raddr = bidx_addr;
    else if (cmd.out_rd || state == ST_OUT) raddr = outi_r;
  end

  r2fft_ram #(.WIDTH(DW), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign tr = ACC_W'((pr_r + 42'sd16384) >>> 15);
  assign ti = ACC_W'((pi_r + 42'sd16384) >>> 15);

  always_ff @(posedge clk) begin
    if (cmd.rd_b) begin
      ar_r <= rdata[DW-1:ACC_W];
      ai_r <= rdata[ACC_W-1:0];
      wr_r <= tw_cos(tw);
      wi_r <= inv_r ? tw_sin(tw) : -tw_sin(tw);
    end
    if (cmd.mul) begin
      pr_r <= 42'(wr_r * $signed(rdata[DW-1:ACC_W])) - 42'(wi_r * $signed(rdata[ACC_W-1:0]));
      pi_r <= 42'(wr_r * $signed(rdata[ACC_W-1:0])) + 42'(wi_r * $signed(rdata[DW-1:ACC_W]));
    end
  end

  logic signed [ACC_W:0] vr, vi, rnd;
  assign rnd = (ACC_W+1)'((ACC_W+1)'(1) << (eff_l - 3'd1));
  always_comb begin
    vr = $signed({rdata[DW-1], rdata[DW-1:ACC_W]});
    vi = $signed({rdata[ACC_W-1], rdata[ACC_W-1:0]});
    if (!inv_r) begin
      vr = (vr + rnd) >>> eff_l;
      vi = (vi + rnd) >>> eff_l;
    end
  end

  // read data is stable for the whole output state
  assign bin_re = vr[BIN_W-1:0];
  assign bin_im = vi[BIN_W-1:0];

endmodule

>>> tb/tb_radix2_fft_frame_core.sv
module tb_radix2_fft_frame_core;
  import r2fft_pkg::*;

  typedef struct {
    logic signed [BIN_W-1:0] re;
    logic signed [BIN_W-1:0] im;
    logic                    last;
  } bin_t;

  typedef enum logic {ROW_CFG, ROW_SMP} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [0:0]         idx;
    logic [SIZE_W-1:0]  data;
    int                 re;
    int                 im;
    bit                 typed;
    int                 b0re, b0im, b1re, b1im;
  } row_t;

  localparam int WATCHDOG = 20000;
  localparam int SETTLE = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SMP_W-1:0] in_sample_re = '0;
  logic signed [SMP_W-1:0] in_sample_im = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [BIN_W-1:0] out_bin_re;
  logic signed [BIN_W-1:0] out_bin_im;
  logic out_last_bin;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = CFG_SIZE;
  logic [SIZE_W-1:0] cfg_data = '0;

  radix2_fft_frame_core dut (.*);

  always #5 clk = ~clk;

  // transform model state
  int unsigned frame_size_reg;
  int unsigned frame_inverse;
  int unsigned samples_loaded;
  longint frame_re[64];
  longint frame_im[64];
  bin_t expected_bins[$];
  bin_t fresh_bins[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  const int cos_q15[17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
                            20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

  function automatic int unsigned active_log2();
    if (frame_size_reg == 0) return 1;
    if (frame_size_reg > 6) return 6;
    return frame_size_reg;
  endfunction

  function automatic longint tw_c(int unsigned t);
    t = t & 31;
    return (t <= 16) ? cos_q15[t] : -cos_q15[32 - t];
  endfunction

  function automatic longint tw_s(int unsigned t);
    t = t & 31;
    return (t <= 16) ? cos_q15[16 - t] : cos_q15[t - 16];
  endfunction

  function automatic longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // Loads one sample; on frame completion fills fresh_bins with the transform.
  function automatic void fft_take_sample(int re, int im);
    int unsigned l, n, addr, s, k, j, m, half, t;
    longint xr[64], xi[64];
    longint wr, wi, tr, ti, ur, ui, vr, vi;
    bin_t b;
    l = active_log2();
    n = 1 << l;
    addr = 0;
    for (int q = 0; q < l; q++) addr = (addr << 1) | (((samples_loaded & 63) >> q) & 1);
    frame_re[addr] = re;
    frame_im[addr] = im;
    samples_loaded = (samples_loaded + 1) & 127;
    fresh_bins.delete();
    if (samples_loaded < n) return;
    samples_loaded = 0;
    for (int q = 0; q < n; q++) begin
      xr[q] = frame_re[q];
      xi[q] = frame_im[q];
    end
    for (s = 1; s <= l; s++) begin
      m = 1 << s;
      half = m >> 1;
      for (k = 0; k < n; k += m) begin
        for (j = 0; j < half; j++) begin
          t = j * (64 >> s);
          wr = tw_c(t);
          wi = frame_inverse ? tw_s(t) : -tw_s(t);
          tr = (wr * xr[k+j+half] - wi * xi[k+j+half] + 16384) >>> 15;
          ti = (wr * xi[k+j+half] + wi * xr[k+j+half] + 16384) >>> 15;
          ur = xr[k+j];
          ui = xi[k+j];
          xr[k+j] = ur + tr;
          xi[k+j] = ui + ti;
          xr[k+j+half] = ur - tr;
          xi[k+j+half] = ui - ti;
        end
      end
    end
    for (int q = 0; q < n; q++) begin
      vr = xr[q];
      vi = xi[q];
      if (!frame_inverse) begin
        vr = (vr + (64'sd1 <<< (l - 1))) >>> l;
        vi = (vi + (64'sd1 <<< (l - 1))) >>> l;
      end
      b.re = BIN_W'(clip24(vr));
      b.im = BIN_W'(clip24(vi));
      b.last = (q == n - 1);
      fresh_bins.push_back(b);
    end
  endfunction

  task automatic wait_drained();
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [SIZE_W-1:0] data);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SIZE) begin
      frame_size_reg = data;
      samples_loaded = 0;
    end else begin
      frame_inverse = data[0];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(int re, int im, bit typed = 0, int b0re = 0, int b0im = 0,
                             int b1re = 0, int b1im = 0);
    bin_t b;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_re <= re[15:0];
    in_sample_im <= im[15:0];
    do @(posedge clk); while (!in_ready);
    fft_take_sample(re, im);
    if (typed && fresh_bins.size() == 2) begin
      b.re = BIN_W'(b0re); b.im = BIN_W'(b0im); b.last = 1'b0;
      expected_bins.push_back(b);
      b.re = BIN_W'(b1re); b.im = BIN_W'(b1im); b.last = 1'b1;
      expected_bins.push_back(b);
    end else begin
      foreach (fresh_bins[q]) expected_bins.push_back(fresh_bins[q]);
    end
  endtask

  function automatic int pick_sample();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32767;
    if (r == 1) return -32768;
    return $signed(16'($urandom));
  endfunction

  always @(posedge clk) begin
    if (hold_req && hold_left == 0) hold_left <= 600;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    bin_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bins.size() == 0) begin
        $error("unexpected bin re=%0d im=%0d", out_bin_re, out_bin_im);
        errors++;
      end else begin
        e = expected_bins.pop_front();
        if (out_bin_re !== e.re) begin
          $error("bin_re expected %0d actual %0d", e.re, out_bin_re);
          errors++;
        end
        if (out_bin_im !== e.im) begin
          $error("bin_im expected %0d actual %0d", e.im, out_bin_im);
          errors++;
        end
        if (out_last_bin !== e.last) begin
          $error("last_bin expected %0d actual %0d", e.last, out_last_bin);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  row_t rows[] = '{
    '{ROW_CFG, CFG_SIZE, 3'd1, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_CFG, CFG_MODE, 3'd0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_SMP, CFG_SIZE, 3'd0, 32767, -32768, 0, 0, 0, 0, 0},
    '{ROW_SMP, CFG_SIZE, 3'd0, -32768, 32767, 1, 0, 0, 32768, -32767},
    '{ROW_CFG, CFG_MODE, 3'd1, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_SMP, CFG_SIZE, 3'd0, 32767, 32767, 0, 0, 0, 0, 0},
    '{ROW_SMP, CFG_SIZE, 3'd0, 32767, 32767, 1, 65534, 65534, 0, 0},
    '{ROW_CFG, CFG_SIZE, 3'd0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_SMP, CFG_SIZE, 3'd0, -32768, -32768, 0, 0, 0, 0, 0},
    '{ROW_SMP, CFG_SIZE, 3'd0, -32768, -32768, 1, -65536, -65536, 0, 0},
    '{ROW_CFG, CFG_SIZE, 3'd2, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_SMP, CFG_SIZE, 3'd0, 1234, -4321, 0, 0, 0, 0, 0},
    '{ROW_SMP, CFG_SIZE, 3'd0, -1, 1, 0, 0, 0, 0, 0},
    '{ROW_CFG, CFG_SIZE, 3'd2, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_SMP, CFG_SIZE, 3'd0, 32767, 0, 0, 0, 0, 0, 0},
    '{ROW_SMP, CFG_SIZE, 3'd0, 0, 32767, 0, 0, 0, 0, 0},
    '{ROW_SMP, CFG_SIZE, 3'd0, -32768, 0, 0, 0, 0, 0, 0},
    '{ROW_SMP, CFG_SIZE, 3'd0, 0, -32768, 0, 0, 0, 0, 0},
    '{ROW_CFG, CFG_MODE, 3'd0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_SMP, CFG_SIZE, 3'd0, 32767, -32768, 0, 0, 0, 0, 0},
    '{ROW_SMP, CFG_SIZE, 3'd0, 32767, -32768, 0, 0, 0, 0, 0},
    '{ROW_SMP, CFG_SIZE, 3'd0, -32768, 32767, 0, 0, 0, 0, 0},
    '{ROW_SMP, CFG_SIZE, 3'd0, -32768, 32767, 0, 0, 0, 0, 0}
  };

  // size, mode, frames
  int plan[11][3] = '{'{1, 0, 8}, '{2, 1, 6}, '{3, 0, 4}, '{6, 1, 1}, '{4, 1, 3},
                      '{7, 0, 1}, '{5, 0, 2}, '{0, 1, 6}, '{3, 1, 4}, '{2, 0, 6},
                      '{4, 0, 3}};

  initial begin
    int n;
    frame_size_reg = 6;
    frame_inverse = 0;
    samples_loaded = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      if (rows[r].kind == ROW_CFG)
        write_reg(rows[r].idx, rows[r].data);
      else
        send_sample(rows[r].re, rows[r].im, rows[r].typed, rows[r].b0re, rows[r].b0im,
                    rows[r].b1re, rows[r].b1im);
    end

    for (int p = 0; p < 11; p++) begin
      write_reg(CFG_SIZE, SIZE_W'(plan[p][0]));
      write_reg(CFG_MODE, SIZE_W'(plan[p][1]));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      n = 1 << active_log2();
      if (p == 2) hold_req = 1'b1;
      for (int f = 0; f < plan[p][2]; f++) begin
        for (int q = 0; q < n; q++) send_sample(pick_sample(), pick_sample());
        hold_req = 1'b0;
      end
    end
    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_bins.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> radix2_fft_frame_core.f
src/r2fft_pkg.sv
src/r2fft_ram.sv
src/r2fft_ctrl.sv
src/r2fft_dp.sv
src/radix2_fft_frame_core.sv
tb/tb_radix2_fft_frame_core.sv
